[hw/rtl/hce_pkg.sv]
// ----------------------------------------------------------------------------
// Hill cipher encryptor package
// Shared widths, register indexes, the closed-block record and the key lookup.
// ----------------------------------------------------------------------------
package hce_pkg;

  localparam int MaxOrder   = 4;
  localparam int ByteW      = 8;
  localparam int OrderW     = 2;   // order minus one, 0..3
  localparam int KeyW       = 128; // sixteen flat key entries
  localparam int ValueW     = 18;
  localparam int TdataOutW  = 24;  // cipher value padded to whole bytes
  localparam int CfgDataW   = 64;
  localparam int CfgIndexW  = 2;
  localparam int KeyOrderW  = 3;

  typedef enum logic [CfgIndexW-1:0] {
    REG_KEY_ORDER = 2'd0,
    REG_KEY_LOW   = 2'd1,
    REG_KEY_HIGH  = 2'd2
  } cfg_reg_t;

  typedef logic [MaxOrder-1:0][ByteW-1:0] byte_vec_t;

  // A closed block waiting to be multiplied out column by column.
  typedef struct packed {
    byte_vec_t             bytes;   // positions beyond the block are zero
    logic [OrderW-1:0]     n_m1;    // order of the key in use, minus one
    logic                  eom;     // block was closed by the message end
  } blk_t;

  // Flat key entry k, entry 0 in the lowest byte.
  function automatic logic [ByteW-1:0] key_entry(input logic [KeyW-1:0] key,
                                                 input logic [3:0] k);
    key_entry = key[k*ByteW +: ByteW];
  endfunction

endpackage

[hw/rtl/hce_column.sv]
// ----------------------------------------------------------------------------
// Hill cipher column unit
// Dot product of one closed block with one column of the key matrix.
// ----------------------------------------------------------------------------
module hce_column
  import hce_pkg::*;
(
  input  blk_t                blk,
  input  logic [KeyW-1:0]     key,
  input  logic [OrderW-1:0]   col,
  output logic [ValueW-1:0]   value
);

  logic [OrderW:0]        order;
  logic [3:0]             idx   [MaxOrder];
  logic [2*ByteW-1:0]     prod  [MaxOrder];

  assign order = {1'b0, blk.n_m1} + 3'd1;

  // Row i of the key starts at flat entry i*n. Rows beyond the order meet
  // zero bytes, so their index never matters.
  always_comb begin
    for (int i = 0; i < MaxOrder; i++) begin
      idx[i]  = 4'(i) * {1'b0, order} + {2'b00, col};
      prod[i] = 16'(blk.bytes[i]) * 16'(key_entry(key, idx[i]));
    end
  end

  assign value = ValueW'(prod[0]) + ValueW'(prod[1]) + ValueW'(prod[2])
               + ValueW'(prod[3]);

endmodule

[hw/rtl/hill_cipher_encryptor_core.sv]
// ----------------------------------------------------------------------------
// Hill cipher encryptor core
// Streams message bytes in, multiplies each block of n bytes by the n x n key
// matrix and streams the n ciphertext values out.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Payload                         Request rule
//   s_axis    in         tdata[7:0] message byte,         tvalid & tready
//                        tlast end of message
//   m_axis    out        tdata[17:0] cipher value,        tvalid & tready
//                        tlast last value of message
//   cfg       in         cfg_index, cfg_data              cfg_we
//
// A byte that completes a block (or carries end of message) moves the block
// into a holding register; the column unit then produces one value per cycle
// into the output register while the output is not stalled, so a block of n
// bytes yields its n values and, while the output flows, n-byte blocks stream
// at one byte per cycle. A partial block flushed by end of message still
// yields n values, so while the output flows a request that closes the next
// block straight away waits for the holding register.
// Reset (rst, synchronous) empties the buffer, the holding register and the
// output register and loads the key order 2 and an all-zero key.
// A stalled output only blocks a request that would close a block while the
// holding register is still busy; other bytes are buffered as usual.
// ----------------------------------------------------------------------------
module hill_cipher_encryptor_core
  import hce_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // Configuration write port
  input  logic                  cfg_we,
  input  logic [CfgIndexW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0]   cfg_data,
  // Input stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [ByteW-1:0]      s_axis_tdata,   // [7:0] message_byte
  input  logic                  s_axis_tlast,   // end_of_message
  // Output stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [TdataOutW-1:0]  m_axis_tdata,   // [17:0] cipher_value, rest zero
  output logic                  m_axis_tlast    // last_value
);

  // Configuration registers.
  logic [KeyOrderW-1:0]  key_order;
  logic [KeyW-1:0]       key;

  // Block buffer and fill count.
  byte_vec_t             buffer;
  logic [OrderW-1:0]     fill_count;

  // Holding register for a closed block, with its column counter.
  blk_t                  blk;
  logic                  blk_valid;
  logic [OrderW-1:0]     col;

  // Output register.
  logic                  out_valid;
  logic [ValueW-1:0]     out_value;
  logic                  out_last;

  logic [OrderW-1:0]     n_m1;
  logic [OrderW:0]       count;
  logic [OrderW:0]       order;
  logic [OrderW:0]       used;
  logic                  closes;
  logic                  in_accept;
  logic                  out_load;
  logic                  blk_done;
  logic [ValueW-1:0]     col_value;
  blk_t                  blk_next;

  // Effective order: a key order of zero acts as one, anything above the
  // maximum acts as the maximum.
  always_comb begin
    if (key_order == '0) begin
      n_m1 = '0;
    end else if (key_order > KeyOrderW'(MaxOrder)) begin
      n_m1 = OrderW'(MaxOrder - 1);
    end else begin
      n_m1 = OrderW'(key_order - KeyOrderW'(1));
    end
  end

  assign order = {1'b0, n_m1} + 3'd1;
  assign count = {1'b0, fill_count} + 3'd1;

  // The block closes when it is full (also when the order has shrunk below
  // what is already buffered) or when the byte ends the message.
  assign closes = (count >= order) || s_axis_tlast;
  assign used   = (count < order) ? count : order;

  // The output register takes a new value from the held block whenever it is empty or drained.
  assign out_load = blk_valid && (!out_valid || m_axis_tready);
  assign blk_done = out_load && (col == blk.n_m1);

  assign s_axis_tready = !closes || !blk_valid || blk_done;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  // Closed block: the new byte lands at its fill position; positions past
  // the used length count as zero.
  always_comb begin
    for (int i = 0; i < MaxOrder; i++) begin
      if (3'(i) >= used) begin
        blk_next.bytes[i] = '0;
      end else if (OrderW'(i) == fill_count) begin
        blk_next.bytes[i] = s_axis_tdata;
      end else begin
        blk_next.bytes[i] = buffer[i];
      end
    end
    blk_next.n_m1 = n_m1;
    blk_next.eom  = s_axis_tlast;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_order <= KeyOrderW'(2);
      key       <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KEY_ORDER: key_order <= cfg_data[KeyOrderW-1:0];
        REG_KEY_LOW:   key[CfgDataW-1:0]    <= cfg_data;
        REG_KEY_HIGH:  key[KeyW-1:CfgDataW] <= cfg_data;
        default: ;
      endcase
    end
  end

  // The buffer itself needs no clearing: the fill count masks stale bytes.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      buffer[fill_count] <= s_axis_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
    end else if (in_accept) begin
      fill_count <= closes ? '0 : count[OrderW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && closes) begin
      blk <= blk_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      blk_valid <= 1'b0;
      col       <= '0;
    end else if (in_accept && closes) begin
      blk_valid <= 1'b1;
      col       <= '0;
    end else if (blk_done) begin
      blk_valid <= 1'b0;
      col       <= '0;
    end else if (out_load) begin
      col <= col + OrderW'(1);
    end
  end

  hce_column u_column (
    .blk   (blk),
    .key   (key),
    .col   (col),
    .value (col_value)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || m_axis_tready) begin
      out_valid <= blk_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_value <= col_value;
      out_last  <= blk.eom && (col == blk.n_m1);
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(TdataOutW-ValueW){1'b0}}, out_value};
  assign m_axis_tlast  = out_last;

endmodule

[hw/rtl/hce_checker.sv]
// ----------------------------------------------------------------------------
// Hill cipher encryptor port checker
// Watches the top-level ports over time and reports broken invariants.
// ----------------------------------------------------------------------------
module hce_checker
  import hce_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tready,
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic [TdataOutW-1:0]  m_axis_tdata,
  input  logic                  m_axis_tlast
);

  localparam logic [ValueW-1:0] MaxValue = ValueW'(MaxOrder * 255 * 255);

  // A stalled value must not change under the consumer.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output request changed while stalled");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[TdataOutW-1:ValueW] == '0)
    else $error("padding bits of output data not zero");

  a_value_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[ValueW-1:0] <= MaxValue)
    else $error("cipher value beyond largest dot product");

  // Nothing can be pending straight after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");

  // With the holding register empty after reset, any byte is taken.
  a_reset_ready: assert property (@(posedge clk)
    rst |=> s_axis_tready)
    else $error("input not ready right after reset");

endmodule

bind hill_cipher_encryptor_core hce_checker u_hce_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
